// File: hdl/stack_machine_execute_macros.svh
// ----------------------------------------------------------------------------
// Stack machine execute assertion macros
// Concurrent assertion wrappers on clk, with and without the rst disable.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_MACROS_SVH
`define STACK_MACHINE_EXECUTE_MACROS_SVH

`ifndef SYNTHESIS
`define SME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SME_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SME_ASSERT(lbl, prop, msg)
`define SME_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hdl/sme_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine execute package
// Field widths, opcodes, status codes and the decoded control struct.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int OP_W          = 8;
  localparam int IMM_W         = 56;
  localparam int WORD_W        = 64;
  localparam int PROGRAM_WORDS = 4096;
  localparam int IP_W          = $clog2(PROGRAM_WORDS);
  localparam int STATUS_W      = 3;
  localparam int COUNT_W       = 11;

  typedef enum logic [OP_W-1:0] {
    OP_HALT   = 8'h00,
    OP_PUSH   = 8'h01,
    OP_ADDI   = 8'h02,
    OP_LTI    = 8'h03,
    OP_JNZ    = 8'h04,
    OP_DUP    = 8'h05,
    OP_GTI    = 8'h06,
    OP_EQI    = 8'h07,
    OP_NOT    = 8'h08,
    OP_SUBI   = 8'h09,
    OP_ADD    = 8'h0A,
    OP_SUB    = 8'h0B,
    OP_EQ     = 8'h0C,
    OP_LT     = 8'h0D,
    OP_GT     = 8'h0E,
    OP_JMP    = 8'h0F,
    OP_SAVE   = 8'h10,
    OP_LOAD   = 8'h11
  } op_t;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_RUN   = 3'd0;
  localparam status_t ST_DONE  = 3'd1;
  localparam status_t ST_BADOP = 3'd2;
  localparam status_t ST_UNDER = 3'd3;
  localparam status_t ST_OVER  = 3'd4;
  localparam status_t ST_ADDR  = 3'd5;

  typedef struct packed {
    logic       known;
    logic [1:0] pops;
    logic [1:0] pushes;
    logic       grow;
    logic       mem_op;
  } dec_t;

endpackage

// File: hdl/sme_decode.sv
// ----------------------------------------------------------------------------
// Stack machine opcode decoder
// Stack effect, growth and data memory use of one opcode.
// ----------------------------------------------------------------------------
module sme_decode (
  input  logic [sme_pkg::OP_W-1:0] action,
  output sme_pkg::dec_t            dec
);
  import sme_pkg::*;

  always_comb begin
    dec = '0;
    unique case (action) inside
      OP_HALT, OP_JMP: begin
        dec.known = 1'b1;
      end
      OP_PUSH: begin
        dec.known  = 1'b1;
        dec.pushes = 2'd1;
        dec.grow   = 1'b1;
      end
      OP_ADDI, OP_LTI, OP_GTI, OP_EQI, OP_NOT, OP_SUBI: begin
        dec.known  = 1'b1;
        dec.pops   = 2'd1;
        dec.pushes = 2'd1;
      end
      OP_ADD, OP_SUB, OP_EQ, OP_LT, OP_GT: begin
        dec.known  = 1'b1;
        dec.pops   = 2'd2;
        dec.pushes = 2'd1;
      end
      OP_JNZ: begin
        dec.known = 1'b1;
        dec.pops  = 2'd1;
      end
      OP_DUP: begin
        dec.known  = 1'b1;
        dec.pops   = 2'd1;
        dec.pushes = 2'd2;
        dec.grow   = 1'b1;
      end
      OP_SAVE: begin
        dec.known  = 1'b1;
        dec.pops   = 2'd1;
        dec.mem_op = 1'b1;
      end
      OP_LOAD: begin
        dec.known  = 1'b1;
        dec.pushes = 2'd1;
        dec.grow   = 1'b1;
        dec.mem_op = 1'b1;
      end
      default: begin
        dec = '0;
      end
    endcase
  end

endmodule

// File: hdl/stack_machine_execute.sv
// ----------------------------------------------------------------------------
// Stack machine execute
// Runs one instruction per request against an operand stack and data memory.
//
// Input channel: in_valid/in_stall with action (opcode) and immediate.
// Output channel: out_valid/out_stall with next_ip, status, top_value and
// stack_count, one result per request, in request order.
// An accepted request passes through the read stage (stack RAM and data RAM
// read), then the execute stage, which writes back and registers its result
// in the output registers. No new request is taken while the read stage is
// busy: the stack RAM read of one instruction must follow the write-back
// of the one before it. The top of stack is held in a register.
// After reset the data memory is swept to zero, one word per cycle, over all
// DATA_WORDS addresses; in_stall stays high for that time. Stack RAM is not
// cleared. While out_stall holds a result, the execute stage waits and
// in_stall rises. Once status is nonzero, later requests only report state.
// ----------------------------------------------------------------------------
`include "stack_machine_execute_macros.svh"

module stack_machine_execute #(
  parameter int STACK_ENTRIES = 1024,
  parameter int DATA_WORDS    = 8192
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sme_pkg::OP_W-1:0]      action,
  input  logic [sme_pkg::IMM_W-1:0]     immediate,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sme_pkg::IP_W-1:0]      next_ip,
  output logic [sme_pkg::STATUS_W-1:0]  status,
  output logic [sme_pkg::WORD_W-1:0]    top_value,
  output logic [sme_pkg::COUNT_W-1:0]   stack_count
);
  import sme_pkg::*;

  localparam int SW = $clog2(STACK_ENTRIES);
  localparam int DW = $clog2(STACK_ENTRIES + 1);
  localparam int AW = $clog2(DATA_WORDS);

  logic [WORD_W-1:0] stack_mem [STACK_ENTRIES];
  logic [WORD_W-1:0] data_mem  [DATA_WORDS];

  logic              clearing;
  logic [AW-1:0]     clr_addr;

  logic              s1_valid;
  logic [OP_W-1:0]   s1_action;
  logic [IMM_W-1:0]  s1_imm;
  logic              s2_valid;
  logic [OP_W-1:0]   s2_action;
  logic [IMM_W-1:0]  s2_imm;

  logic [IP_W-1:0]   ip;
  status_t           halt;
  logic [DW-1:0]     depth;
  logic [WORD_W-1:0] top;

  logic [WORD_W-1:0] stack_rd;
  logic [WORD_W-1:0] data_rd;

  logic [IP_W-1:0]   ip_next;
  status_t           halt_next;
  logic [DW-1:0]     depth_next;
  logic [WORD_W-1:0] top_next;
  logic              stk_push;
  logic              store_ok;

  dec_t              dec;
  logic              in_take;
  logic              s2_go;
  logic [WORD_W-1:0] imm64;
  logic [WORD_W-1:0] result;
  logic              under;
  logic              over;
  logic              addr_bad;
  logic              jump;
  logic [SW-1:0]     stk_raddr;
  logic [SW-1:0]     stk_waddr;
  logic              dm_we;
  logic [AW-1:0]     dm_waddr;
  logic [WORD_W-1:0] dm_wdata;
  logic [DW+COUNT_W-1:0] count_ext;

  sme_decode u_decode (
    .action (s2_action),
    .dec    (dec)
  );

  assign s2_go    = s2_valid && (!out_valid || !out_stall);
  assign in_stall = clearing || s1_valid || (s2_valid && !s2_go);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DATA_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_take;
      if (s1_valid) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action <= action;
      s1_imm    <= immediate;
    end
    if (s1_valid) begin
      s2_action <= s1_action;
      s2_imm    <= s1_imm;
    end
  end

  assign stk_raddr = SW'(depth - DW'(2));
  assign stk_waddr = SW'(depth_next - DW'(1));

  always_ff @(posedge clk) begin
    if (s2_go && stk_push) begin
      stack_mem[stk_waddr] <= top_next;
    end
    stack_rd <= stack_mem[stk_raddr];
  end

  assign dm_we    = clearing || (s2_go && store_ok);
  assign dm_waddr = clearing ? clr_addr : s2_imm[AW-1:0];
  assign dm_wdata = clearing ? '0 : top;

  always_ff @(posedge clk) begin
    if (dm_we) begin
      data_mem[dm_waddr] <= dm_wdata;
    end
    data_rd <= data_mem[s1_imm[AW-1:0]];
  end

  assign imm64    = {{(WORD_W - IMM_W){1'b0}}, s2_imm};
  assign under    = depth < DW'(dec.pops);
  assign over     = dec.grow && (depth == DW'(STACK_ENTRIES));
  assign addr_bad = imm64 >= WORD_W'(DATA_WORDS);

  always_comb begin
    case (s2_action) inside
      OP_PUSH:  result = imm64;
      OP_ADDI:  result = top + imm64;
      OP_SUBI:  result = top - imm64;
      OP_LTI:   result = {{(WORD_W - 1){1'b0}}, top < imm64};
      OP_GTI:   result = {{(WORD_W - 1){1'b0}}, top > imm64};
      OP_EQI:   result = {{(WORD_W - 1){1'b0}}, top == imm64};
      OP_NOT:   result = {{(WORD_W - 1){1'b0}}, top == '0};
      OP_ADD:   result = stack_rd + top;
      OP_SUB:   result = stack_rd - top;
      OP_EQ:    result = {{(WORD_W - 1){1'b0}}, stack_rd == top};
      OP_LT:    result = {{(WORD_W - 1){1'b0}}, stack_rd < top};
      OP_GT:    result = {{(WORD_W - 1){1'b0}}, stack_rd > top};
      OP_LOAD:  result = data_rd;
      default:  result = top;
    endcase
  end

  always_comb begin
    ip_next    = ip;
    halt_next  = halt;
    depth_next = depth;
    top_next   = top;
    stk_push   = 1'b0;
    store_ok   = 1'b0;
    jump       = (s2_action == OP_JMP) || ((s2_action == OP_JNZ) && (top != '0));
    if (halt == ST_RUN) begin
      if (!dec.known) begin
        halt_next = ST_BADOP;
        ip_next   = ip + IP_W'(1);
      end else if (s2_action == OP_HALT) begin
        halt_next = ST_DONE;
        ip_next   = ip + IP_W'(1);
      end else if (under) begin
        halt_next = ST_UNDER;
      end else if (over) begin
        halt_next = ST_OVER;
      end else if (dec.mem_op && addr_bad) begin
        halt_next = ST_ADDR;
      end else begin
        depth_next = depth - DW'(dec.pops) + DW'(dec.pushes);
        if (dec.pushes != 2'd0) begin
          stk_push = 1'b1;
          top_next = result;
        end else if (dec.pops != 2'd0) begin
          top_next = stack_rd;
        end
        store_ok = (s2_action == OP_SAVE);
        ip_next  = jump ? s2_imm[IP_W+2:3] : ip + IP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ip    <= '0;
      halt  <= ST_RUN;
      depth <= '0;
    end else if (s2_go) begin
      ip    <= ip_next;
      halt  <= halt_next;
      depth <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      top <= top_next;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, depth_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      next_ip     <= ip_next;
      status      <= halt_next;
      top_value   <= (depth_next != '0) ? top_next : '0;
      stack_count <= count_ext[COUNT_W-1:0];
    end
  end

  `SME_ASSERT_ALWAYS(a_clear_blocks_input, clearing |-> in_stall, "request taken during clear")
  `SME_ASSERT(a_one_in_flight, !(s1_valid && s2_valid), "read and execute stages both busy")
  `SME_ASSERT(a_read_feeds_exec, s1_valid |=> s2_valid, "read stage did not advance to execute")
  `SME_ASSERT(a_halt_sticks, (halt != ST_RUN) |=> (halt == $past(halt)), "halt status changed")
  `SME_ASSERT(a_depth_bound, depth <= DW'(STACK_ENTRIES), "stack depth beyond capacity")

endmodule
